/* sv/indexed_char_sequence_store_unit_defines.svh */
// assertion macros for the indexed char sequence store
// used by the top level only, no other dependencies
`ifndef INDEXED_CHAR_SEQUENCE_STORE_UNIT_DEFINES_SVH
`define INDEXED_CHAR_SEQUENCE_STORE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ICS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ICS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ICS_ASSERT_IMP(lbl, ante, cons, msg)
`define ICS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/ics_pkg.sv */
// shared types and codes for the indexed char sequence store
// no dependencies
package ics_pkg;
  localparam int DefaultDepth = 64;
  localparam int ModeW  = 4;
  localparam int PosW   = 7;
  localparam int ValW   = 8;
  localparam int StatW  = 2;
  localparam int CountW = 7;

  localparam logic [ModeW-1:0] MODE_PUSH_BACK   = 4'd0;
  localparam logic [ModeW-1:0] MODE_PUSH_FRONT  = 4'd1;
  localparam logic [ModeW-1:0] MODE_INSERT_AT   = 4'd2;
  localparam logic [ModeW-1:0] MODE_INSERT_ORD  = 4'd3;
  localparam logic [ModeW-1:0] MODE_REMOVE_AT   = 4'd4;
  localparam logic [ModeW-1:0] MODE_POP_FRONT   = 4'd5;
  localparam logic [ModeW-1:0] MODE_POP_BACK    = 4'd6;
  localparam logic [ModeW-1:0] MODE_REPLACE_AT  = 4'd7;
  localparam logic [ModeW-1:0] MODE_READ_AT     = 4'd8;
  localparam logic [ModeW-1:0] MODE_CLEAR       = 4'd9;

  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_RANGE = 2'd1;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd2;
  localparam logic [StatW-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [PosW-1:0]  position;
    logic [ValW-1:0]  value;
  } in_req_t;

  typedef struct packed {
    logic [ValW-1:0]   read_value;
    logic [StatW-1:0]  status;
    logic [CountW-1:0] item_count;
    logic [ValW-1:0]   first_value;
    logic [ValW-1:0]   last_value;
    logic              is_empty;
  } out_rsp_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic apply;
  } ctrl_cmd_t;
endpackage

/* sv/indexed_char_sequence_store_unit.sv */
// Ordered store of up to DEPTH bytes held in a row of cells that all shift in the same cycle.
// Each item is accepted, then the request and the per-cell compares are evaluated, then
// the row is shifted, then the result is presented; the next item is accepted after the
// result leaves. Cells need no clearing.
// top level, depends on ics_pkg, ics_ctrl, ics_datapath and the defines header
`include "indexed_char_sequence_store_unit_defines.svh"
module indexed_char_sequence_store_unit import ics_pkg::*; #(
  parameter int DEPTH = DefaultDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_rsp_t out_o
);
  ctrl_cmd_t cmd;

  ics_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd)
  );

  ics_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_i, .out_o
  );

  `ICS_ASSERT_IMP(a_no_overlap, in_ready_o, !out_valid_o, "ready while result pending")
  `ICS_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o,
                  "accepted a second item")
  `ICS_ASSERT_IMP(a_empty_front, out_valid_o && out_o.is_empty,
                  out_o.first_value == '0 && out_o.last_value == '0, "empty store shows data")
endmodule

/* sv/ics_ctrl.sv */
// request sequencer: accept, evaluate, apply, respond
// depends on ics_pkg
module ics_ctrl import ics_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ctrl_cmd_t cmd_o
);
  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_APPLY, S_RESP} state_e;
  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE:  if (in_valid_i) state_q <= S_EVAL;
        S_EVAL:  state_q <= S_APPLY;
        S_APPLY: state_q <= S_RESP;
        S_RESP:  if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_RESP);
  assign cmd_o.capture = in_ready_o && in_valid_i;
  assign cmd_o.eval    = (state_q == S_EVAL);
  assign cmd_o.apply   = (state_q == S_APPLY);
endmodule

/* sv/ics_datapath.sv */
// row of cells with parallel shift, count and response registers
// depends on ics_pkg
module ics_datapath import ics_pkg::*; #(
  parameter int DEPTH = DefaultDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_cmd_t cmd_i,
  input  in_req_t   in_i,
  output out_rsp_t  out_o
);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int IW = (CW > PosW) ? CW : PosW;

  typedef enum logic [2:0] {OP_NONE, OP_INS, OP_REM, OP_REP, OP_CLR} op_e;

  logic [ValW-1:0]  cells_q [DEPTH];
  logic [ValW-1:0]  cells_d [DEPTH];
  logic [CW-1:0]    count_q, count_d;
  in_req_t          req_q;
  op_e              op_q, op_d;
  logic [StatW-1:0] status_q, status_d;
  logic [ValW-1:0]  rd_q, rd_d;
  logic [DEPTH-1:0] m_q, m_d, p;
  logic [IW-1:0]    idx, cnt_x, pos_x;
  logic             ord, full;

  assign cnt_x = IW'(count_q);
  assign pos_x = IW'(req_q.position);
  assign full  = (count_q >= CW'(DEPTH));

  always_comb begin
    op_d     = OP_NONE;
    status_d = ST_OK;
    rd_d     = '0;
    idx      = '0;
    ord      = 1'b0;
    unique case (req_q.mode)
      MODE_PUSH_BACK, MODE_PUSH_FRONT, MODE_INSERT_AT, MODE_INSERT_ORD: begin
        if (req_q.mode == MODE_PUSH_BACK) idx = cnt_x;
        else if (req_q.mode == MODE_INSERT_AT) idx = pos_x;
        ord = (req_q.mode == MODE_INSERT_ORD);
        if (!ord && idx > cnt_x) status_d = ST_RANGE;
        else if (full) status_d = ST_FULL;
        else op_d = OP_INS;
      end
      MODE_REMOVE_AT: begin
        idx = pos_x;
        if (pos_x >= cnt_x) status_d = ST_RANGE;
        else op_d = OP_REM;
      end
      MODE_POP_FRONT: begin
        if (count_q == '0) status_d = ST_EMPTY;
        else op_d = OP_REM;
      end
      MODE_POP_BACK: begin
        idx = cnt_x - IW'(1);
        if (count_q == '0) status_d = ST_EMPTY;
        else op_d = OP_REM;
      end
      MODE_REPLACE_AT: begin
        idx = pos_x;
        if (pos_x >= cnt_x) status_d = ST_RANGE;
        else op_d = OP_REP;
      end
      MODE_READ_AT: begin
        if (pos_x >= cnt_x) status_d = ST_RANGE;
        else rd_d = cells_q[pos_x[AW-1:0]];
      end
      MODE_CLEAR: op_d = OP_CLR;
      default: op_d = OP_NONE;
    endcase
    for (int i = 0; i < DEPTH; i++) begin
      if (ord) m_d[i] = (IW'(i) >= cnt_x) || (req_q.value <= cells_q[i]);
      else     m_d[i] = (IW'(i) >= idx);
    end
  end

  // first flagged cell and everything behind it
  always_comb begin
    p[0] = m_q[0];
    for (int i = 1; i < DEPTH; i++) p[i] = p[i-1] | m_q[i];
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic edge_pt;
    logic [ValW-1:0] prev_v, next_v;
    if (g == 0) begin : g_first
      assign edge_pt = p[0];
      assign prev_v  = cells_q[0];
    end else begin : g_rest
      assign edge_pt = p[g] && !p[g-1];
      assign prev_v  = cells_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_v = cells_q[g];
    end else begin : g_mid
      assign next_v = cells_q[g+1];
    end
    always_comb begin
      cells_d[g] = cells_q[g];
      unique case (op_q)
        OP_INS: begin
          if (edge_pt) cells_d[g] = req_q.value;
          else if (p[g]) cells_d[g] = prev_v;
        end
        OP_REM: if (p[g]) cells_d[g] = next_v;
        OP_REP: if (edge_pt) cells_d[g] = req_q.value;
        default: cells_d[g] = cells_q[g];
      endcase
    end
    always_ff @(posedge clk_i) begin
      if (cmd_i.apply) cells_q[g] <= cells_d[g];
    end
  end

  always_comb begin
    unique case (op_q)
      OP_INS:  count_d = count_q + CW'(1);
      OP_REM:  count_d = count_q - CW'(1);
      OP_CLR:  count_d = '0;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.apply) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= in_i;
    if (cmd_i.eval) begin
      op_q     <= op_d;
      status_q <= status_d;
      rd_q     <= rd_d;
      m_q      <= m_d;
    end
  end

  logic [CW-1:0] last_idx;
  assign last_idx = count_q - CW'(1);

  assign out_o.read_value  = rd_q;
  assign out_o.status      = status_q;
  assign out_o.item_count  = CountW'(count_q);
  assign out_o.is_empty    = (count_q == '0);
  assign out_o.first_value = out_o.is_empty ? '0 : cells_q[0];
  assign out_o.last_value  = out_o.is_empty ? '0 : cells_q[last_idx[AW-1:0]];
endmodule
